>>> hw/rtl/eprd_pkg.sv
// Package for the entropy pool random divider: item kinds, hash constants,
// controller states and the command and status structs between the two halves.
// No dependencies.
`default_nettype none

package eprd_pkg;

  typedef enum logic [1:0] {
    KIND_MIX    = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_SCALE  = 2'd2,
    KIND_DIVIDE = 2'd3
  } kind_e;

  localparam logic [31:0] MIX_MULT    = 32'd251;
  localparam int unsigned MIX_SHIFT   = 7;
  localparam logic [31:0] DRAW_BIAS   = 32'hDEADBEEF;
  localparam logic [31:0] DRAW_MULT   = 32'd19;
  localparam logic [31:0] HASH_MULT0  = 32'd12345;
  localparam logic [31:0] HASH_MULT1  = 32'd54321;
  localparam int unsigned HASH_SHIFT0 = 11;
  localparam int unsigned HASH_SHIFT1 = 13;

  // Scaling keeps bits [46:16] of the 16 by 32 bit product.
  localparam int unsigned PROD_W      = 47;
  localparam int unsigned SCALE_SHIFT = 16;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [32:0] POS_MAX = 33'h0_7FFF_FFFF;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MIX0  = 10'b00_0000_0010,
    S_MIX1  = 10'b00_0000_0100,
    S_DRAW0 = 10'b00_0000_1000,
    S_DRAW1 = 10'b00_0001_0000,
    S_DRAW2 = 10'b00_0010_0000,
    S_DRAW3 = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_SCALE = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MIX_MUL,
    OP_MIX_WR,
    OP_DRAW_MUL0,
    OP_DRAW_MUL1,
    OP_DRAW_MUL2,
    OP_DRAW_WR,
    OP_DIV_STEP,
    OP_SCALE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    kind_e new_kind;
    logic  new_b_zero;
    kind_e kind;
    logic  div_last;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/eprd_req_if.sv
// Request channel of the entropy pool random divider: valid, ready and item fields.
// No dependencies.
`default_nettype none

interface eprd_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/eprd_rsp_if.sv
// Result channel of the entropy pool random divider: valid, ready and result fields.
// No dependencies.
`default_nettype none

interface eprd_rsp_if;
  logic               valid;
  logic               ready;
  logic        [31:0] random_word;
  logic signed [31:0] result_value;

  modport source (output valid, random_word, result_value, input ready);
  modport sink (input valid, random_word, result_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/eprd_ctrl.sv
// Sequencer of the entropy pool random divider: one-hot state machine that issues
// datapath commands and owns both handshakes. Depends on eprd_pkg.
`default_nettype none

module eprd_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire                   rsp_ready_i,
  input  wire eprd_pkg::status_t status_i,
  output eprd_pkg::cmd_t        cmd_o
);

  eprd_pkg::state_e state_q, state_d;
  logic             rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = eprd_pkg::OP_NONE;
    cmd_o.out_load  = 1'b0;
    req_ready_o     = 1'b0;
    case (state_q)
      eprd_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = eprd_pkg::OP_CAPTURE;
          case (status_i.new_kind)
            eprd_pkg::KIND_MIX:    state_d = eprd_pkg::S_MIX0;
            eprd_pkg::KIND_DRAW:   state_d = eprd_pkg::S_DRAW0;
            eprd_pkg::KIND_SCALE:  state_d = eprd_pkg::S_DRAW0;
            eprd_pkg::KIND_DIVIDE: begin
              state_d = status_i.new_b_zero ? eprd_pkg::S_DONE : eprd_pkg::S_DIV;
            end
            default:               state_d = eprd_pkg::S_IDLE;
          endcase
        end
      end
      eprd_pkg::S_MIX0: begin
        cmd_o.op = eprd_pkg::OP_MIX_MUL;
        state_d  = eprd_pkg::S_MIX1;
      end
      eprd_pkg::S_MIX1: begin
        cmd_o.op = eprd_pkg::OP_MIX_WR;
        state_d  = eprd_pkg::S_IDLE;
      end
      eprd_pkg::S_DRAW0: begin
        cmd_o.op = eprd_pkg::OP_DRAW_MUL0;
        state_d  = eprd_pkg::S_DRAW1;
      end
      eprd_pkg::S_DRAW1: begin
        cmd_o.op = eprd_pkg::OP_DRAW_MUL1;
        state_d  = eprd_pkg::S_DRAW2;
      end
      eprd_pkg::S_DRAW2: begin
        cmd_o.op = eprd_pkg::OP_DRAW_MUL2;
        state_d  = eprd_pkg::S_DRAW3;
      end
      eprd_pkg::S_DRAW3: begin
        cmd_o.op = eprd_pkg::OP_DRAW_WR;
        state_d  = (status_i.kind == eprd_pkg::KIND_DRAW) ? eprd_pkg::S_DONE
                                                          : eprd_pkg::S_SCALE;
      end
      eprd_pkg::S_DIV: begin
        cmd_o.op = eprd_pkg::OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = eprd_pkg::S_DRAW0;
        end
      end
      eprd_pkg::S_SCALE: begin
        cmd_o.op = eprd_pkg::OP_SCALE;
        state_d  = eprd_pkg::S_DONE;
      end
      eprd_pkg::S_DONE: begin
        // Wait here until the output register is free or being emptied.
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = eprd_pkg::S_IDLE;
        end
      end
      default: state_d = eprd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eprd_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/eprd_datapath.sv
// Datapath of the entropy pool random divider: pool memory with valid bits,
// hash multipliers, restoring divider, scaler and output register. Depends on eprd_pkg.
`default_nettype none

module eprd_datapath #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire         [1:0]        req_kind_i,
  input  wire  signed [31:0]       req_operand_a_i,
  input  wire  signed [31:0]       req_operand_b_i,
  input  wire eprd_pkg::cmd_t      cmd_i,
  output eprd_pkg::status_t        status_o,
  output logic        [31:0]       rsp_random_word_o,
  output logic signed [31:0]       rsp_result_value_o
);

  localparam int unsigned PTR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_DEPTH - 1);

  logic [31:0]            mem_q [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]  valid_q;
  logic [31:0]            rd_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [PTR_W-1:0]       ptr_nxt;

  eprd_pkg::kind_e        kind_q;
  logic [31:0]            a_q;
  logic                   b_zero_q;
  logic                   neg_q;
  logic                   bneg_q;
  logic [31:0]            mb_q;
  logic [31:0]            t_q;
  logic [31:0]            word_q;
  logic [eprd_pkg::PROD_W-1:0] prod_q;
  logic [31:0]            rem_q;
  logic [31:0]            quo_q;
  logic [eprd_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [31:0]            rsp_word_q;
  logic [31:0]            rsp_value_q;

  logic [31:0]            a_u, b_u, ma, mb;
  logic                   rd_en, wr_en, ptr_adv;
  logic [PTR_W-1:0]       rd_addr;
  logic [31:0]            wr_data;
  logic [31:0]            hx0, hx1, mix_x;
  logic [32:0]            shifted;
  logic                   fits;
  logic [47:0]            prod_full;
  logic [31:0]            s_ext, scaled;
  logic                   inc;
  logic [32:0]            q_inc;
  logic [31:0]            q_sat, quot, value;

  assign a_u = req_operand_a_i;
  assign b_u = req_operand_b_i;
  assign ma  = a_u[31] ? (~a_u + 32'd1) : a_u;
  assign mb  = b_u[31] ? (~b_u + 32'd1) : b_u;

  assign ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
  assign ptr_adv = (cmd_i.op == eprd_pkg::OP_MIX_MUL) || (cmd_i.op == eprd_pkg::OP_DRAW_MUL0);
  assign rd_en   = (cmd_i.op == eprd_pkg::OP_CAPTURE) || ptr_adv;
  assign rd_addr = (cmd_i.op == eprd_pkg::OP_CAPTURE) ? ptr_q : ptr_nxt;
  assign wr_en   = (cmd_i.op == eprd_pkg::OP_MIX_WR) || (cmd_i.op == eprd_pkg::OP_DRAW_WR);

  assign mix_x   = t_q ^ (t_q >> eprd_pkg::MIX_SHIFT);
  assign wr_data = (cmd_i.op == eprd_pkg::OP_MIX_WR) ? (rd_q + mix_x) : (rd_q ^ t_q);
  assign hx0     = t_q ^ (t_q >> eprd_pkg::HASH_SHIFT0);
  assign hx1     = t_q ^ (t_q >> eprd_pkg::HASH_SHIFT1);

  // One restoring division step per cycle, quotient bits shift in from the right.
  assign shifted = {rem_q, quo_q[31]};
  assign fits    = shifted >= {1'b0, mb_q};

  assign prod_full = {32'd0, word_q[15:0]} * {16'd0, mb_q};

  // Pool storage; entries never written read as zero through their valid bits.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= valid_q[rd_addr] ? mem_q[rd_addr] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (wr_en) begin
        valid_q[ptr_q] <= 1'b1;
      end
      if (ptr_adv) begin
        ptr_q <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      eprd_pkg::OP_CAPTURE: begin
        kind_q   <= eprd_pkg::kind_e'(req_kind_i);
        a_q      <= a_u;
        b_zero_q <= (b_u == 32'd0);
        neg_q    <= a_u[31] ^ b_u[31];
        bneg_q   <= b_u[31];
        mb_q     <= mb;
        word_q   <= 32'd0;
        rem_q    <= 32'd0;
        quo_q    <= ma;
        cnt_q    <= '0;
      end
      eprd_pkg::OP_MIX_MUL:   t_q <= a_q + rd_q * eprd_pkg::MIX_MULT;
      eprd_pkg::OP_DRAW_MUL0: t_q <= eprd_pkg::DRAW_BIAS + rd_q * eprd_pkg::DRAW_MULT;
      eprd_pkg::OP_DRAW_MUL1: t_q <= hx0 * eprd_pkg::HASH_MULT0;
      eprd_pkg::OP_DRAW_MUL2: t_q <= hx1 * eprd_pkg::HASH_MULT1;
      eprd_pkg::OP_DRAW_WR:   word_q <= t_q;
      eprd_pkg::OP_DIV_STEP: begin
        rem_q <= fits ? 32'(shifted - {1'b0, mb_q}) : shifted[31:0];
        quo_q <= {quo_q[30:0], fits};
        cnt_q <= cnt_q + eprd_pkg::DIV_CNT_W'(1);
      end
      eprd_pkg::OP_SCALE:     prod_q <= prod_full[eprd_pkg::PROD_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    s_ext  = {1'b0, prod_q[eprd_pkg::PROD_W-1:eprd_pkg::SCALE_SHIFT]};
    scaled = bneg_q ? (~s_ext + 32'd1) : s_ext;
    inc    = s_ext < rem_q;
    q_inc  = {1'b0, quo_q} + {32'd0, inc};
    q_sat  = (!neg_q && (q_inc > eprd_pkg::POS_MAX)) ? eprd_pkg::POS_MAX[31:0] : q_inc[31:0];
    quot   = neg_q ? (~q_sat + 32'd1) : q_sat;
    case (kind_q)
      eprd_pkg::KIND_DRAW:   value = word_q;
      eprd_pkg::KIND_SCALE:  value = scaled;
      eprd_pkg::KIND_DIVIDE: value = b_zero_q ? a_q : quot;
      default:               value = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_word_q  <= word_q;
      rsp_value_q <= value;
    end
  end

  assign status_o.new_kind   = eprd_pkg::kind_e'(req_kind_i);
  assign status_o.new_b_zero = (b_u == 32'd0);
  assign status_o.kind       = kind_q;
  assign status_o.div_last   = (cnt_q == eprd_pkg::DIV_CNT_W'(eprd_pkg::DIV_STEPS - 1));

  assign rsp_random_word_o  = rsp_word_q;
  assign rsp_result_value_o = rsp_value_q;

endmodule

`default_nettype wire

>>> hw/rtl/entropy_pool_random_divider.sv
// Top level of the entropy pool random divider: controller plus datapath.
// Depends on eprd_pkg, eprd_req_if, eprd_rsp_if, eprd_ctrl and eprd_datapath.
//
//   channel  direction  fields                              transaction when
//   req_i    in         kind, operand_a, operand_b          valid && ready
//   rsp_o    out        random_word, result_value           valid && ready
//
// From accept to result: draw runs the draw states, scaled adds the scale state, divide
// by zero goes straight to done, and divide runs the one-bit-per-cycle divider, then draw
// and scale. Ready returns in the cycle after the result is loaded; a mix gives no result.
// One item is in work at a time; ready is high only while the sequencer idles.
// A finished result sits in the output register; the next item is taken meanwhile,
// and stalls in its last state while that register stays full.
// Reset clears the pool at once through per-entry valid bits and the pointer to zero.
`default_nettype none

module entropy_pool_random_divider #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  eprd_req_if.sink     req_i,
  eprd_rsp_if.source   rsp_o
);

  eprd_pkg::cmd_t    cmd;
  eprd_pkg::status_t status;
  logic              req_ready;
  logic              rsp_valid;

  eprd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eprd_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_kind_i         (req_i.kind),
    .req_operand_a_i    (req_i.operand_a),
    .req_operand_b_i    (req_i.operand_b),
    .cmd_i              (cmd),
    .status_o           (status),
    .rsp_random_word_o  (rsp_o.random_word),
    .rsp_result_value_o (rsp_o.result_value)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

  // A result may only be loaded when the output register is free or draining.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result loaded over an unread result");

  a_ready_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !cmd.out_load)
    else $error("result load while accepting a new item");

  a_mix_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.kind == eprd_pkg::KIND_MIX))
      |=> (cmd.op == eprd_pkg::OP_MIX_MUL))
    else $error("mix item did not start the mix sequence");

  a_div_to_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.op == eprd_pkg::OP_DIV_STEP) && status.div_last)
      |=> (cmd.op == eprd_pkg::OP_DRAW_MUL0))
    else $error("division end did not start the draw");

endmodule

`default_nettype wire
